>>> design/lss_pkg.sv
// Shared types, widths and index tables for the Cramer's rule solver.
package lss_pkg;

  localparam int COEF_W   = 16;
  localparam int FRAC     = 16;
  localparam int PROD_W   = 2 * COEF_W;
  localparam int COF_W    = PROD_W + 1;
  localparam int TERM_W   = COEF_W + COF_W;
  localparam int DET_W    = TERM_W + 1;
  localparam int OUT_W    = 32;
  localparam int Q_BITS   = OUT_W + 1;
  localparam int X_W      = DET_W + FRAC;
  localparam int DIV_LAT  = Q_BITS + 3;
  localparam int PIPE_LAT = DIV_LAT + 6;

  typedef logic [3:0] idx_t;

  localparam idx_t PA [18] = '{4'd4, 4'd5, 4'd5, 4'd3, 4'd3, 4'd4, 4'd2, 4'd1, 4'd0,
                               4'd2, 4'd1, 4'd0, 4'd1, 4'd2, 4'd2, 4'd0, 4'd0, 4'd1};
  localparam idx_t PB [18] = '{4'd8, 4'd7, 4'd6, 4'd8, 4'd7, 4'd6, 4'd7, 4'd8, 4'd8,
                               4'd6, 4'd6, 4'd7, 4'd5, 4'd4, 4'd3, 4'd5, 4'd4, 4'd3};

  typedef struct packed {
    logic [OUT_W-1:0] res;
    logic             sat;
  } div_res_t;

endpackage

>>> design/linear_system_solver_2x2_3x3.sv
// Top level of the Cramer's rule solver for 2x2 and 3x3 systems.
// One request is taken every clock cycle and busy never rises; the result strobe
// out_valid is raised after its request passes five register stages of input capture,
// cofactor and determinant arithmetic, the 36-stage division pipeline
// (33 quotient steps plus its input and output registers) and the output register.
// The receiver cannot stall, so results must be captured on the strobe cycle.
module linear_system_solver_2x2_3x3 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic signed [15:0] in_m11,
  input  logic signed [15:0] in_m12,
  input  logic signed [15:0] in_m13,
  input  logic signed [15:0] in_rhs1,
  input  logic signed [15:0] in_m21,
  input  logic signed [15:0] in_m22,
  input  logic signed [15:0] in_m23,
  input  logic signed [15:0] in_rhs2,
  input  logic signed [15:0] in_m31,
  input  logic signed [15:0] in_m32,
  input  logic signed [15:0] in_m33,
  input  logic signed [15:0] in_rhs3,
  output logic               out_valid,
  output logic signed [31:0] out_sol_x,
  output logic signed [31:0] out_sol_y,
  output logic signed [31:0] out_sol_z,
  output logic               out_singular,
  output logic               out_saturated
);

  localparam int CW = lss_pkg::COEF_W;
  localparam int DL = lss_pkg::DIV_LAT;

  logic size_r;
  logic v_r [5];

  logic signed [CW-1:0] a0_r [9];
  logic signed [CW-1:0] a1_r [9];
  logic signed [CW-1:0] a2_r [9];
  logic signed [CW-1:0] r0_r [3];
  logic signed [CW-1:0] r1_r [3];
  logic signed [CW-1:0] r2_r [3];

  logic signed [lss_pkg::PROD_W-1:0] p_r [18];
  logic signed [lss_pkg::COF_W-1:0]  c_r [9];
  logic signed [lss_pkg::TERM_W-1:0] e_r [4][3];
  logic signed [lss_pkg::DET_W-1:0]  s_r [4];

  logic dv_r [DL];
  logic ds_r [DL];

  lss_pkg::div_res_t q [3];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 1'b1;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) v_r[i] <= 1'b0;
      for (int i = 0; i < DL; i++) dv_r[i] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v_r[0] <= start && !busy;
      for (int i = 1; i < 5; i++) v_r[i] <= v_r[i-1];
      dv_r[0] <= v_r[4];
      for (int i = 1; i < DL; i++) dv_r[i] <= dv_r[i-1];
      out_valid <= dv_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    a0_r[0] <= in_m11;
    a0_r[1] <= in_m12;
    a0_r[3] <= in_m21;
    a0_r[4] <= in_m22;
    r0_r[0] <= in_rhs1;
    r0_r[1] <= in_rhs2;
    if (size_r) begin
      a0_r[2] <= in_m13;
      a0_r[5] <= in_m23;
      a0_r[6] <= in_m31;
      a0_r[7] <= in_m32;
      a0_r[8] <= in_m33;
      r0_r[2] <= in_rhs3;
    end else begin
      a0_r[2] <= '0;
      a0_r[5] <= '0;
      a0_r[6] <= '0;
      a0_r[7] <= '0;
      a0_r[8] <= CW'(1);
      r0_r[2] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 18; i++) p_r[i] <= a0_r[lss_pkg::PA[i]] * a0_r[lss_pkg::PB[i]];
    for (int i = 0; i < 9; i++) a1_r[i] <= a0_r[i];
    for (int i = 0; i < 3; i++) r1_r[i] <= r0_r[i];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      c_r[i] <= lss_pkg::COF_W'(p_r[2*i]) - lss_pkg::COF_W'(p_r[2*i+1]);
    end
    for (int i = 0; i < 9; i++) a2_r[i] <= a1_r[i];
    for (int i = 0; i < 3; i++) r2_r[i] <= r1_r[i];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e_r[0][i] <= a2_r[i*3] * c_r[i*3];
      for (int j = 0; j < 3; j++) e_r[j+1][i] <= r2_r[i] * c_r[i*3+j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      s_r[j] <= lss_pkg::DET_W'(e_r[j][0]) + lss_pkg::DET_W'(e_r[j][1])
              + lss_pkg::DET_W'(e_r[j][2]);
    end
  end

  always_ff @(posedge clk) begin
    ds_r[0] <= (s_r[0] == '0);
    for (int i = 1; i < DL; i++) ds_r[i] <= ds_r[i-1];
  end

  for (genvar j = 0; j < 3; j++) begin : g_div
    lss_div u_div (
      .clk   (clk),
      .n_in  (s_r[j+1]),
      .d_in  (s_r[0]),
      .q_out (q[j])
    );
  end

  always_ff @(posedge clk) begin
    if (ds_r[DL-1]) begin
      out_sol_x     <= '0;
      out_sol_y     <= '0;
      out_sol_z     <= '0;
      out_singular  <= 1'b1;
      out_saturated <= 1'b0;
    end else begin
      out_sol_x     <= q[0].res;
      out_sol_y     <= q[1].res;
      out_sol_z     <= q[2].res;
      out_singular  <= 1'b0;
      out_saturated <= q[0].sat | q[1].sat | q[2].sat;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(lss_pkg::PIPE_LAT) out_valid)
    else $error("request did not produce a result at the expected latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, lss_pkg::PIPE_LAT))
    else $error("result strobe without a matching request");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_sol_x == '0 && out_sol_y == '0
                                  && out_sol_z == '0 && !out_saturated)
    else $error("singular result carries nonzero data");

endmodule

>>> design/lss_div.sv
// Pipelined restoring divider with saturation to the signed Q16.16 range.
module lss_div (
  input  logic                                clk,
  input  logic signed [lss_pkg::DET_W-1:0]    n_in,
  input  logic signed [lss_pkg::DET_W-1:0]    d_in,
  output lss_pkg::div_res_t                   q_out
);

  localparam int DW = lss_pkg::DET_W;
  localparam int QB = lss_pkg::Q_BITS;
  localparam int XW = lss_pkg::X_W;

  logic [DW-1:0] na_r, da_r;
  logic          nega_r;

  logic [DW-1:0] rem_r [QB+1];
  logic [QB-1:0] xl_r  [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic [DW-1:0] d_r   [QB+1];
  logic          neg_r [QB+1];
  logic          ovf_r [QB+1];

  logic [XW-1:0] x_full;
  logic [QB-1:0] limit;
  logic          sat_nxt;
  logic [QB-1:0] mag;
  logic [QB-1:0] sgn;

  always_ff @(posedge clk) begin
    na_r   <= n_in[DW-1] ? DW'(-n_in) : DW'(n_in);
    da_r   <= d_in[DW-1] ? DW'(-d_in) : DW'(d_in);
    nega_r <= n_in[DW-1] ^ d_in[DW-1];
  end

  assign x_full = {na_r, {lss_pkg::FRAC{1'b0}}};

  always_ff @(posedge clk) begin
    rem_r[0] <= DW'(x_full[XW-1:QB]);
    xl_r[0]  <= x_full[QB-1:0];
    q_r[0]   <= '0;
    d_r[0]   <= da_r;
    neg_r[0] <= nega_r;
    ovf_r[0] <= DW'(x_full[XW-1:QB]) >= da_r;
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0] sh;
    logic [DW:0] diff;
    assign sh   = {rem_r[k], xl_r[k][QB-1]};
    assign diff = sh - {1'b0, d_r[k]};
    always_ff @(posedge clk) begin
      rem_r[k+1] <= diff[DW] ? sh[DW-1:0] : diff[DW-1:0];
      q_r[k+1]   <= {q_r[k][QB-2:0], ~diff[DW]};
      xl_r[k+1]  <= {xl_r[k][QB-2:0], 1'b0};
      d_r[k+1]   <= d_r[k];
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
    end
  end

  always_comb begin
    limit   = neg_r[QB] ? (QB'(1) << (lss_pkg::OUT_W - 1))
                        : ((QB'(1) << (lss_pkg::OUT_W - 1)) - QB'(1));
    sat_nxt = ovf_r[QB] || (q_r[QB] > limit);
    mag     = sat_nxt ? limit : q_r[QB];
    sgn     = neg_r[QB] ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    q_out.res <= sgn[lss_pkg::OUT_W-1:0];
    q_out.sat <= sat_nxt;
  end

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the 2x2/3x3 Cramer's rule solver with a built-in predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               sing, sat;
  } solution_t;

  typedef logic signed [15:0] coef_arr_t [12];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic signed [15:0] m [12] = '{default: '0};
  logic out_valid;
  logic signed [31:0] out_sol_x, out_sol_y, out_sol_z;
  logic out_singular, out_saturated;

  logic      size_3x3;
  solution_t pending_solutions [$];
  int        error_count = 0;
  longint    cycle_count = 0;
  int        idle_pct = 38;

  always #5 clk = ~clk;

  linear_system_solver_2x2_3x3 u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_m11(m[0]), .in_m12(m[1]), .in_m13(m[2]), .in_rhs1(m[3]),
    .in_m21(m[4]), .in_m22(m[5]), .in_m23(m[6]), .in_rhs2(m[7]),
    .in_m31(m[8]), .in_m32(m[9]), .in_m33(m[10]), .in_rhs3(m[11]),
    .out_valid(out_valid), .out_sol_x(out_sol_x), .out_sol_y(out_sol_y),
    .out_sol_z(out_sol_z), .out_singular(out_singular), .out_saturated(out_saturated)
  );

  function automatic logic signed [63:0] det3(logic signed [63:0] k [9]);
    return k[0] * (k[4] * k[8] - k[5] * k[7])
         - k[1] * (k[3] * k[8] - k[5] * k[6])
         + k[2] * (k[3] * k[7] - k[4] * k[6]);
  endfunction

  function automatic logic signed [31:0] clamp_div(logic signed [63:0] num,
                                                   logic signed [63:0] den, ref logic sat);
    logic signed [127:0] n, d, q;
    n = 128'(num) <<< 16;
    d = 128'(den);
    q = n / d;
    if (q > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic solution_t solve_system(coef_arr_t c, logic three);
    logic signed [63:0] a [9];
    logic signed [63:0] t [9];
    logic signed [63:0] b [3];
    logic signed [63:0] d;
    logic signed [31:0] r [3];
    logic sat;
    solution_t s;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) a[i*3+j] = c[i*4+j];
      b[i] = c[i*4+3];
    end
    if (!three) begin
      a[2] = 0; a[5] = 0; a[6] = 0; a[7] = 0; a[8] = 1; b[2] = 0;
    end
    d = det3(a);
    s = '{0, 0, 0, 1'b0, 1'b0};
    if (d == 0) begin
      s.sing = 1'b1;
      return s;
    end
    sat = 1'b0;
    for (int col = 0; col < 3; col++) begin
      t = a;
      for (int i = 0; i < 3; i++) t[i*3+col] = b[i];
      r[col] = clamp_div(det3(t), d, sat);
    end
    s.x = r[0]; s.y = r[1]; s.z = r[2]; s.sat = sat;
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    solution_t e;
    if (rst_n && out_valid) begin
      if (pending_solutions.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        e = pending_solutions.pop_front();
        if (out_sol_x !== e.x) report_mismatch("sol_x", out_sol_x, e.x);
        if (out_sol_y !== e.y) report_mismatch("sol_y", out_sol_y, e.y);
        if (out_sol_z !== e.z) report_mismatch("sol_z", out_sol_z, e.z);
        if (out_singular !== e.sing) report_mismatch("singular", out_singular, e.sing);
        if (out_saturated !== e.sat) report_mismatch("saturated", out_saturated, e.sat);
      end
    end
  end

  task automatic send_request(coef_arr_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    for (int i = 0; i < 12; i++) m[i] <= c[i];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_solutions.push_back(solve_system(c, size_3x3));
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_solutions.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_size(logic three);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= three;
    @(negedge clk);
    cfg_we <= 1'b0;
    size_3x3 = three;
  endtask

  function automatic coef_arr_t random_system(int mode);
    coef_arr_t c;
    for (int i = 0; i < 12; i++) begin
      case (mode)
        0: c[i] = 16'($urandom);
        1: c[i] = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
        default: c[i] = $signed(16'($urandom_range(0, 15))) - 16'sd8;
      endcase
    end
    if (mode == 3) begin
      for (int j = 0; j < 4; j++) c[4+j] = c[j];
    end
    return c;
  endfunction

  task automatic test_directed();
    coef_arr_t c;
    for (int s = 0; s < 2; s++) begin
      write_size(s[0]);
      c = '{256, 0, 0, 256, 0, 256, 0, -256, 0, 0, 256, 512};
      send_request(c);
      c = '{default: 0};
      send_request(c);
      c = '{default: 16'sh7fff};
      send_request(c);
      c = '{default: -16'sh8000};
      send_request(c);
      c = '{1, 0, 0, 16'sh7fff, 0, 1, 0, -16'sh8000, 0, 0, 1, 16'sh7fff};
      send_request(c);
      c = '{-16'sh8000, 16'sh7fff, 5, 16'sh7fff, 16'sh7fff, -16'sh8000, -3, -16'sh8000,
            1, 2, 3, 4};
      send_request(c);
      c = '{1, 2, 3, 7, 2, 4, 6, 9, 0, 1, 5, 2};
      send_request(c);
    end
  endtask

  task automatic test_random_3x3();
    write_size(1'b1);
    for (int i = 0; i < 800; i++) send_request(random_system($urandom_range(3)));
  endtask

  task automatic test_random_2x2();
    write_size(1'b0);
    for (int i = 0; i < 600; i++) send_request(random_system($urandom_range(3)));
  endtask

  task automatic test_back_to_back();
    write_size(1'b1);
    idle_pct = 0;
    for (int i = 0; i < 300; i++) send_request(random_system($urandom_range(3)));
    idle_pct = 38;
    drain_results();
    for (int i = 0; i < 100; i++) send_request(random_system($urandom_range(3)));
  endtask

  initial begin
    size_3x3 = 1'b1;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_3x3();
    test_random_2x2();
    test_back_to_back();
    drain_results();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
